// ===== src/ipv4p_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4p_pkg
// Shared types and constants for the dotted IPv4 address text parser.
// ----------------------------------------------------------------------------
package ipv4p_pkg;

  localparam int CHAR_W    = 8;
  localparam int VALUE_W   = 9;
  localparam int COUNT_W   = 3;
  localparam int ADDR_W    = 32;
  localparam int OCTET_W   = 8;
  localparam int NUM_PARTS = 4;

  localparam logic [VALUE_W-1:0] VALUE_CAP  = 9'd256;
  localparam logic [COUNT_W-1:0] PART_LIMIT = 3'd4;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2e;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_ONE   = 8'h31;
  localparam logic [CHAR_W-1:0] CHAR_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LO_F  = 8'h66;
  localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UP_F  = 8'h46;
  localparam logic [CHAR_W-1:0] CHAR_LO_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CHAR_UP_X  = 8'h58;

  typedef enum logic [2:0] {
    PH_START,
    PH_LEAD,
    PH_SIGN,
    PH_ZERO,
    PH_ZEROX,
    PH_DIGITS,
    PH_DEAD
  } phase_t;

  typedef enum logic [1:0] {
    BASE_DEC,
    BASE_OCT,
    BASE_HEX
  } base_t;

  typedef struct packed {
    logic       is_nul;
    logic       is_space;
    logic       is_sign;
    logic       is_minus;
    logic       is_dot;
    logic       is_x;
    logic       is_zero;
    logic       is_dec_lead;
    logic       is_hex;
    logic [3:0] digit;
  } char_class_t;

endpackage

// ===== src/ipv4p_char_class.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4p_char_class
// Decodes one text byte into class flags and its hex digit value.
// ----------------------------------------------------------------------------
module ipv4p_char_class (
  input  logic [ipv4p_pkg::CHAR_W-1:0] character,
  output ipv4p_pkg::char_class_t       cls
);

  logic is_num;
  logic is_lo;
  logic is_up;

  always_comb begin
    is_num = (character >= ipv4p_pkg::CHAR_ZERO) && (character <= ipv4p_pkg::CHAR_NINE);
    is_lo  = (character >= ipv4p_pkg::CHAR_LO_A) && (character <= ipv4p_pkg::CHAR_LO_F);
    is_up  = (character >= ipv4p_pkg::CHAR_UP_A) && (character <= ipv4p_pkg::CHAR_UP_F);

    cls.is_nul      = (character == ipv4p_pkg::CHAR_NUL);
    cls.is_space    = (character == ipv4p_pkg::CHAR_SPACE) ||
                      ((character >= ipv4p_pkg::CHAR_TAB) && (character <= ipv4p_pkg::CHAR_CR));
    cls.is_minus    = (character == ipv4p_pkg::CHAR_MINUS);
    cls.is_sign     = cls.is_minus || (character == ipv4p_pkg::CHAR_PLUS);
    cls.is_dot      = (character == ipv4p_pkg::CHAR_DOT);
    cls.is_x        = (character == ipv4p_pkg::CHAR_LO_X) ||
                      (character == ipv4p_pkg::CHAR_UP_X);
    cls.is_zero     = (character == ipv4p_pkg::CHAR_ZERO);
    cls.is_dec_lead = (character >= ipv4p_pkg::CHAR_ONE) && (character <= ipv4p_pkg::CHAR_NINE);
    cls.is_hex      = is_num || is_lo || is_up;

    if (is_num) begin
      cls.digit = 4'(character - ipv4p_pkg::CHAR_ZERO);
    end else if (is_lo) begin
      cls.digit = 4'(character - ipv4p_pkg::CHAR_LO_A + 8'd10);
    end else if (is_up) begin
      cls.digit = 4'(character - ipv4p_pkg::CHAR_UP_A + 8'd10);
    end else begin
      cls.digit = 4'd0;
    end
  end

endmodule

// ===== src/ipv4_dotted_text_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_dotted_text_parser
// Parses dotted IPv4 address text, one byte per transfer, ending with NUL.
// The result of a NUL passes through the input register and then the result
// register before it is on the outputs. Throughput: one byte per cycle; the
// input stalls only while a NUL waits behind a stalled result.
// Reset (rst, synchronous) clears the parse state and both registers' valid.
// ----------------------------------------------------------------------------
module ipv4_dotted_text_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ipv4p_pkg::CHAR_W-1:0]  character,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          parse_ok,
  output logic [ipv4p_pkg::ADDR_W-1:0]  address,
  output logic [ipv4p_pkg::COUNT_W-1:0] parts_seen
);

  // input register
  logic                         in_full;
  logic [ipv4p_pkg::CHAR_W-1:0] char_q;
  ipv4p_pkg::char_class_t       cls;

  // parse state
  ipv4p_pkg::phase_t               phase, phase_next;
  logic [ipv4p_pkg::COUNT_W-1:0]   part_count, part_count_next;
  ipv4p_pkg::base_t                number_base, number_base_next;
  logic [ipv4p_pkg::VALUE_W-1:0]   part_value, part_value_next;
  logic                            minus_seen, minus_seen_next;
  logic [ipv4p_pkg::OCTET_W-1:0]   octets [ipv4p_pkg::NUM_PARTS];
  logic [ipv4p_pkg::OCTET_W-1:0]   octets_next [ipv4p_pkg::NUM_PARTS];
  logic                            error_seen, error_seen_next;

  logic                          advance;
  logic                          load;
  logic                          do_commit;
  logic                          commit_dot;
  logic                          do_acc;
  logic                          digit_ok;
  logic                          commit_bad;
  logic [ipv4p_pkg::COUNT_W-1:0] count_inc;
  logic [12:0]                   acc_sum;
  logic [1:0]                    addr_class;
  logic                          res_ok;
  logic [ipv4p_pkg::ADDR_W-1:0]  res_addr;

  ipv4p_char_class u_class (
    .character (char_q),
    .cls       (cls)
  );

  // hold a NUL in the input register while the previous result is still stalled
  assign advance  = !(in_full && cls.is_nul && out_valid && out_stall);
  assign in_stall = in_full && !advance;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (load) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
    if (load) begin
      char_q <= character;
    end
  end

  always_comb begin
    phase_next       = phase;
    part_count_next  = part_count;
    number_base_next = number_base;
    part_value_next  = part_value;
    minus_seen_next  = minus_seen;
    error_seen_next  = error_seen;
    for (int i = 0; i < ipv4p_pkg::NUM_PARTS; i++) begin
      octets_next[i] = octets[i];
    end
    do_commit  = 1'b0;
    commit_dot = 1'b0;
    do_acc     = 1'b0;
    res_ok     = 1'b0;
    res_addr   = '0;
    addr_class = 2'd0;

    unique case (number_base)
      ipv4p_pkg::BASE_OCT: digit_ok = cls.is_hex && (cls.digit <= 4'd7);
      ipv4p_pkg::BASE_HEX: digit_ok = cls.is_hex;
      default:             digit_ok = cls.is_hex && (cls.digit <= 4'd9);
    endcase

    if (cls.is_nul) begin
      unique case (phase)
        ipv4p_pkg::PH_START: begin
          if (part_count == '0) begin
            error_seen_next = 1'b1;
            phase_next      = ipv4p_pkg::PH_DEAD;
          end
        end
        ipv4p_pkg::PH_ZERO, ipv4p_pkg::PH_DIGITS: do_commit = 1'b1;
        ipv4p_pkg::PH_DEAD: ;
        default: begin
          error_seen_next = 1'b1;
          phase_next      = ipv4p_pkg::PH_DEAD;
        end
      endcase
    end else begin
      unique case (phase)
        ipv4p_pkg::PH_START, ipv4p_pkg::PH_LEAD, ipv4p_pkg::PH_SIGN: begin
          if (phase == ipv4p_pkg::PH_START && cls.is_dot) begin
            part_value_next = '0;
            do_commit       = 1'b1;
            commit_dot      = 1'b1;
          end else if (phase != ipv4p_pkg::PH_SIGN && cls.is_space) begin
            phase_next = ipv4p_pkg::PH_LEAD;
          end else if (phase != ipv4p_pkg::PH_SIGN && cls.is_sign) begin
            minus_seen_next = cls.is_minus;
            phase_next      = ipv4p_pkg::PH_SIGN;
          end else if (cls.is_zero) begin
            phase_next      = ipv4p_pkg::PH_ZERO;
            part_value_next = '0;
          end else if (cls.is_dec_lead) begin
            phase_next       = ipv4p_pkg::PH_DIGITS;
            number_base_next = ipv4p_pkg::BASE_DEC;
            part_value_next  = ipv4p_pkg::VALUE_W'(cls.digit);
          end else begin
            error_seen_next = 1'b1;
            phase_next      = ipv4p_pkg::PH_DEAD;
          end
        end
        ipv4p_pkg::PH_ZERO: begin
          if (cls.is_x) begin
            phase_next       = ipv4p_pkg::PH_ZEROX;
            number_base_next = ipv4p_pkg::BASE_HEX;
          end else if (cls.is_dot) begin
            do_commit  = 1'b1;
            commit_dot = 1'b1;
          end else if (cls.is_hex && cls.digit <= 4'd7) begin
            number_base_next = ipv4p_pkg::BASE_OCT;
            phase_next       = ipv4p_pkg::PH_DIGITS;
            do_acc           = 1'b1;
          end else begin
            error_seen_next = 1'b1;
            phase_next      = ipv4p_pkg::PH_DEAD;
          end
        end
        ipv4p_pkg::PH_ZEROX: begin
          if (cls.is_hex) begin
            phase_next = ipv4p_pkg::PH_DIGITS;
            do_acc     = 1'b1;
          end else begin
            error_seen_next = 1'b1;
            phase_next      = ipv4p_pkg::PH_DEAD;
          end
        end
        ipv4p_pkg::PH_DIGITS: begin
          if (cls.is_dot) begin
            do_commit  = 1'b1;
            commit_dot = 1'b1;
          end else if (digit_ok) begin
            do_acc = 1'b1;
          end else begin
            error_seen_next = 1'b1;
            phase_next      = ipv4p_pkg::PH_DEAD;
          end
        end
        default: ;
      endcase
    end

    // multiply by 8, 10 or 16 with shifts, then saturate at the cap
    unique case (number_base_next)
      ipv4p_pkg::BASE_HEX: acc_sum = {part_value, 4'b0} + 13'(cls.digit);
      ipv4p_pkg::BASE_OCT: acc_sum = 13'({part_value, 3'b0}) + 13'(cls.digit);
      default: acc_sum = 13'({part_value, 3'b0}) + 13'({part_value, 1'b0}) +
                         13'(cls.digit);
    endcase
    if (do_acc) begin
      part_value_next = (acc_sum >= 13'(ipv4p_pkg::VALUE_CAP)) ?
                        ipv4p_pkg::VALUE_CAP : acc_sum[ipv4p_pkg::VALUE_W-1:0];
    end

    commit_bad = (part_value_next >= ipv4p_pkg::VALUE_CAP) ||
                 (minus_seen && (part_value_next != '0)) ||
                 (part_count >= ipv4p_pkg::PART_LIMIT);
    count_inc  = part_count + 3'd1;
    if (do_commit) begin
      if (commit_bad) begin
        error_seen_next = 1'b1;
        phase_next      = ipv4p_pkg::PH_DEAD;
      end else begin
        octets_next[part_count[1:0]] = part_value_next[ipv4p_pkg::OCTET_W-1:0];
        part_count_next = count_inc;
        if (commit_dot && count_inc >= ipv4p_pkg::PART_LIMIT) begin
          error_seen_next = 1'b1;
          phase_next      = ipv4p_pkg::PH_DEAD;
        end else begin
          phase_next       = ipv4p_pkg::PH_START;
          number_base_next = ipv4p_pkg::BASE_DEC;
          part_value_next  = '0;
          minus_seen_next  = 1'b0;
        end
      end
    end

    if (cls.is_nul) begin
      // expand classful shorthand by the top two bits of the first byte
      addr_class = octets_next[0][7:6];
      if (!error_seen_next) begin
        if (addr_class <= 2'd1) begin
          if (part_count_next == 3'd3) begin
            octets_next[3] = octets_next[2];
            octets_next[2] = octets_next[1];
            octets_next[1] = '0;
          end else if (part_count_next == 3'd2) begin
            octets_next[3] = octets_next[1];
            octets_next[2] = '0;
            octets_next[1] = '0;
          end else if (part_count_next != ipv4p_pkg::PART_LIMIT) begin
            error_seen_next = 1'b1;
          end
        end else if (addr_class == 2'd2) begin
          if (part_count_next == 3'd3) begin
            octets_next[3] = octets_next[2];
            octets_next[2] = '0;
          end else if (part_count_next != ipv4p_pkg::PART_LIMIT) begin
            error_seen_next = 1'b1;
          end
        end
      end
      res_ok = !error_seen_next;
      if (res_ok) begin
        res_addr = {octets_next[0], octets_next[1], octets_next[2], octets_next[3]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (in_full && advance && cls.is_nul)) begin
      phase       <= ipv4p_pkg::PH_START;
      part_count  <= '0;
      number_base <= ipv4p_pkg::BASE_DEC;
      part_value  <= '0;
      minus_seen  <= 1'b0;
      error_seen  <= 1'b0;
      for (int i = 0; i < ipv4p_pkg::NUM_PARTS; i++) begin
        octets[i] <= '0;
      end
    end else if (in_full && advance) begin
      phase       <= phase_next;
      part_count  <= part_count_next;
      number_base <= number_base_next;
      part_value  <= part_value_next;
      minus_seen  <= minus_seen_next;
      error_seen  <= error_seen_next;
      for (int i = 0; i < ipv4p_pkg::NUM_PARTS; i++) begin
        octets[i] <= octets_next[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_full && advance && cls.is_nul) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (in_full && advance && cls.is_nul) begin
      parse_ok   <= res_ok;
      address    <= res_addr;
      parts_seen <= part_count_next;
    end
  end

endmodule

// ===== tb/ipv4_parse_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_parse_checker
// Watches both channels of the dotted IPv4 text parser. It runs its own
// character-level parse of every accepted byte, queues the address it
// expects at each NUL, and compares every accepted result field by field.
// ----------------------------------------------------------------------------
module ipv4_parse_checker
  import ipv4p_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [CHAR_W-1:0]   character,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic                parse_ok,
  input  logic [ADDR_W-1:0]   address,
  input  logic [COUNT_W-1:0]  parts_seen,
  output int                  mismatches,
  output int                  pending
);

  typedef struct packed {
    logic               ok;
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] parts;
  } addr_result_t;

  addr_result_t expected_results[$];

  phase_t             cur_phase;
  logic [COUNT_W-1:0] parts_done;
  base_t              num_base;
  logic [VALUE_W-1:0] part_acc;
  logic               neg_part;
  logic [OCTET_W-1:0] octet_q [NUM_PARTS];
  logic               bad;

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic logic is_blank(logic [CHAR_W-1:0] c);
    return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  // 16 means the byte is not a digit in this base
  function automatic logic [4:0] digit_in_base(logic [CHAR_W-1:0] c, base_t b);
    logic [4:0] d;
    d = 5'd16;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) d = 5'(c - CHAR_ZERO);
    else if (c >= CHAR_LO_A && c <= CHAR_LO_F) d = 5'(c - CHAR_LO_A + 8'd10);
    else if (c >= CHAR_UP_A && c <= CHAR_UP_F) d = 5'(c - CHAR_UP_A + 8'd10);
    if (b == BASE_DEC && d > 5'd9) d = 5'd16;
    if (b == BASE_OCT && d > 5'd7) d = 5'd16;
    return d;
  endfunction

  task automatic clear_parse();
    cur_phase  = PH_START;
    parts_done = '0;
    num_base   = BASE_DEC;
    part_acc   = '0;
    neg_part   = 1'b0;
    foreach (octet_q[i]) octet_q[i] = '0;
    bad        = 1'b0;
  endtask

  task automatic mark_bad();
    bad       = 1'b1;
    cur_phase = PH_DEAD;
  endtask

  task automatic add_digit(logic [4:0] d);
    int v;
    v = int'(part_acc) * (num_base == BASE_HEX ? 16 : (num_base == BASE_OCT ? 8 : 10))
        + int'(d);
    part_acc = (v >= int'(VALUE_CAP)) ? VALUE_CAP : VALUE_W'(v);
  endtask

  task automatic close_part(logic by_dot);
    if (part_acc >= VALUE_CAP || (neg_part && part_acc != '0) || parts_done >= PART_LIMIT) begin
      mark_bad();
      return;
    end
    octet_q[parts_done[1:0]] = part_acc[OCTET_W-1:0];
    parts_done++;
    // a dot after the fourth part is stray text
    if (by_dot && parts_done >= PART_LIMIT) begin
      mark_bad();
      return;
    end
    cur_phase = PH_START;
    num_base  = BASE_DEC;
    part_acc  = '0;
    neg_part  = 1'b0;
  endtask

  task automatic begin_number(logic [CHAR_W-1:0] c);
    if (c == CHAR_ZERO) begin
      cur_phase = PH_ZERO;
      part_acc  = '0;
    end else if (c >= CHAR_ONE && c <= CHAR_NINE) begin
      cur_phase = PH_DIGITS;
      num_base  = BASE_DEC;
      part_acc  = VALUE_W'(c - CHAR_ZERO);
    end else begin
      mark_bad();
    end
  endtask

  task automatic finish_address();
    addr_result_t r;
    case (cur_phase)
      PH_START: if (parts_done == '0) mark_bad();
      PH_ZERO, PH_DIGITS: close_part(1'b0);
      PH_DEAD: ;
      default: mark_bad();
    endcase
    // expand shorthand forms by the class of the first byte
    if (!bad) begin
      case (octet_q[0][7:6])
        2'b00, 2'b01: begin
          if (parts_done == 3'd3) begin
            octet_q[3] = octet_q[2];
            octet_q[2] = octet_q[1];
            octet_q[1] = '0;
          end else if (parts_done == 3'd2) begin
            octet_q[3] = octet_q[1];
            octet_q[2] = '0;
            octet_q[1] = '0;
          end else if (parts_done != 3'd4) begin
            mark_bad();
          end
        end
        2'b10: begin
          if (parts_done == 3'd3) begin
            octet_q[3] = octet_q[2];
            octet_q[2] = '0;
          end else if (parts_done != 3'd4) begin
            mark_bad();
          end
        end
        default: ;
      endcase
    end
    r.ok    = !bad;
    r.addr  = bad ? '0 : {octet_q[0], octet_q[1], octet_q[2], octet_q[3]};
    r.parts = parts_done;
    expected_results.push_back(r);
    clear_parse();
  endtask

  task automatic predict_char(logic [CHAR_W-1:0] c);
    logic [4:0] d;
    if (c == CHAR_NUL) begin
      finish_address();
    end else begin
      case (cur_phase)
        PH_START: begin
          if (c == CHAR_DOT) begin
            part_acc = '0;
            close_part(1'b1);
          end else if (is_blank(c)) begin
            cur_phase = PH_LEAD;
          end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
            neg_part  = (c == CHAR_MINUS);
            cur_phase = PH_SIGN;
          end else begin
            begin_number(c);
          end
        end
        PH_LEAD: begin
          if (c == CHAR_PLUS || c == CHAR_MINUS) begin
            neg_part  = (c == CHAR_MINUS);
            cur_phase = PH_SIGN;
          end else if (!is_blank(c)) begin
            begin_number(c);
          end
        end
        PH_SIGN: begin_number(c);
        PH_ZERO: begin
          d = digit_in_base(c, BASE_OCT);
          if (c == CHAR_LO_X || c == CHAR_UP_X) begin
            cur_phase = PH_ZEROX;
            num_base  = BASE_HEX;
          end else if (c == CHAR_DOT) begin
            close_part(1'b1);
          end else if (d < 5'd16) begin
            num_base  = BASE_OCT;
            cur_phase = PH_DIGITS;
            add_digit(d);
          end else begin
            mark_bad();
          end
        end
        PH_ZEROX: begin
          d = digit_in_base(c, BASE_HEX);
          if (d < 5'd16) begin
            cur_phase = PH_DIGITS;
            add_digit(d);
          end else begin
            mark_bad();
          end
        end
        PH_DIGITS: begin
          d = digit_in_base(c, num_base);
          if (c == CHAR_DOT) close_part(1'b1);
          else if (d < 5'd16) add_digit(d);
          else mark_bad();
        end
        default: ;
      endcase
    end
  endtask

  task automatic check_result();
    addr_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result transfer with no NUL waiting for it");
      return;
    end
    want = expected_results.pop_front();
    if (parse_ok !== want.ok)
      report_mismatch($sformatf("parse_ok got %0b want %0b", parse_ok, want.ok));
    if (address !== want.addr)
      report_mismatch($sformatf("address got %h want %h", address, want.addr));
    if (parts_seen !== want.parts)
      report_mismatch($sformatf("parts_seen got %0d want %0d", parts_seen, want.parts));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_parse();
    end else begin
      if (in_valid && !in_stall) predict_char(character);
      if (out_valid && !out_stall) check_result();
    end
    pending <= expected_results.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives address strings into the dotted IPv4 text parser: a short set of
// corner-case strings, then random addresses in every base and shorthand
// form, some of them broken, plus byte noise. Sender and receiver idle at
// random; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
module tb;
  import ipv4p_pkg::*;

  localparam int RANDOM_ITEMS = 1500;
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 8;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [CHAR_W-1:0]  character;
  logic               out_valid;
  logic               out_stall;
  logic               parse_ok;
  logic [ADDR_W-1:0]  address;
  logic [COUNT_W-1:0] parts_seen;
  int                 mismatches;
  int                 pending;
  int                 idle_cycles;

  logic [CHAR_W-1:0] text_stream[$];

  ipv4_dotted_text_parser i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .character  (character),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .parse_ok   (parse_ok),
    .address    (address),
    .parts_seen (parts_seen)
  );

  ipv4_parse_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .character  (character),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .parse_ok   (parse_ok),
    .address    (address),
    .parts_seen (parts_seen),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic add_text(string s);
    foreach (s[i]) text_stream.push_back(s[i]);
    text_stream.push_back(CHAR_NUL);
  endtask

  task automatic add_part(ref logic [CHAR_W-1:0] txt[$]);
    int    v;
    int    style;
    string s;
    logic [CHAR_W-1:0] c;
    // leave the part empty now and then
    if ($urandom_range(0, 19) == 0) return;
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        v = $urandom_range(0, 5);
        txt.push_back(v == 5 ? CHAR_SPACE : CHAR_TAB + CHAR_W'(v));
      end
    end
    v = $urandom_range(0, 255);
    if ($urandom_range(0, 15) == 0) v = $urandom_range(256, 999);
    if ($urandom_range(0, 31) == 0) v = $urandom_range(1000, 99999);
    case ($urandom_range(0, 9))
      0: txt.push_back(CHAR_PLUS);
      1: begin
        txt.push_back(CHAR_MINUS);
        if ($urandom_range(0, 2) != 0) v = 0;
      end
      default: ;
    endcase
    style = $urandom_range(0, 2);
    if (style == 0) s = $sformatf("%0d", v);
    else if (style == 1) s = {"0", $sformatf("%0o", v)};
    else if ($urandom_range(0, 1) != 0) s = {"0x", $sformatf("%0h", v)};
    else s = {"0X", $sformatf("%0h", v)};
    foreach (s[i]) begin
      c = s[i];
      // mix the case of hex letters
      if (c >= CHAR_LO_A && c <= CHAR_LO_F && $urandom_range(0, 1) != 0) c = c - 8'h20;
      txt.push_back(c);
    end
  endtask

  task automatic add_random_address();
    logic [CHAR_W-1:0] txt[$];
    int n;
    n = ($urandom_range(0, 1) != 0) ? 4 : $urandom_range(1, 5);
    for (int p = 0; p < n; p++) begin
      if (p != 0) txt.push_back(CHAR_DOT);
      add_part(txt);
    end
    if ($urandom_range(0, 19) == 0) txt.push_back(CHAR_DOT);
    // break one byte of some strings
    if (txt.size() != 0 && $urandom_range(0, 7) == 0)
      txt[$urandom_range(0, txt.size() - 1)] = CHAR_W'($urandom_range(1, 255));
    foreach (txt[i]) text_stream.push_back(txt[i]);
    text_stream.push_back(CHAR_NUL);
  endtask

  task automatic add_noise();
    repeat ($urandom_range(0, 6)) text_stream.push_back(CHAR_W'($urandom_range(1, 255)));
    text_stream.push_back(CHAR_NUL);
  endtask

  // receiver: the stall pattern is redrawn from three modes, with one long hold
  initial begin : receiver
    int cyc;
    int mode;
    cyc = 0;
    mode = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (cyc % 64 == 0) mode = $urandom_range(0, 2);
      cyc++;
      if (cyc == HOLD_AT) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int burst;
    int gap;
    int base_len;
    rst = 1'b1;
    in_valid = 1'b0;
    character = CHAR_NUL;

    add_text("");
    add_text("255.255.255.255");
    add_text("0.0.0.0");
    add_text(" \011\012\013\014\015+0x7F.1");
    add_text("10.1.2");
    add_text("128.1.2");
    add_text("128.1");
    add_text("1");
    add_text("192");
    add_text("0377.-0.0XaF.9");
    add_text("256");
    add_text("08");
    add_text("0x");
    add_text(" -");
    add_text("-1");
    add_text("1.2.3.4.");
    add_text("1.2.3.4.5");
    add_text("..1");
    add_text(".");
    add_text("1.2x3");
    add_text("\377");
    base_len = text_stream.size();
    while (text_stream.size() < base_len + RANDOM_ITEMS) begin
      if ($urandom_range(0, 11) == 0) add_noise();
      else add_random_address();
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (text_stream.size() != 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && text_stream.size() != 0) begin
        @(negedge clk);
        in_valid <= 1'b1;
        character <= text_stream[0];
        @(posedge clk);
        // hold the transfer while stalled
        while (in_stall) @(posedge clk);
        void'(text_stream.pop_front());
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        character <= CHAR_W'($urandom_range(0, 255));
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
